// ===== hw/rtl/rfid_tag_block_write_encoder_core_defines.svh =====
// assertion macros for the block write encoder
// used by the top level only; depends on a clk and rst_n in scope
`ifndef RFID_TAG_BLOCK_WRITE_ENCODER_CORE_DEFINES_SVH
`define RFID_TAG_BLOCK_WRITE_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define RTBW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtbw same-cycle check failed");

// next-cycle implication
`define RTBW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtbw next-cycle check failed");

// delayed implication
`define RTBW_ASSERT_TWO(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("rtbw two-cycle check failed");

`endif

// ===== hw/rtl/rtbw_pkg.sv =====
// shared types and constants for the block write encoder
// no dependencies
`timescale 1ns / 1ps

package rtbw_pkg;

  localparam int DATA_BITS = 32;
  localparam int CLK_W     = 10;
  localparam int IDX_W     = 3;
  localparam int POS_W     = 6;
  // opcode (2) + lock (1) + data + address (3) + reset opcode (2)
  localparam int STREAM_W  = DATA_BITS + 8;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // symbol kinds
  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_ZERO    = 3'd1;
  localparam logic [2:0] KIND_ONE     = 3'd2;
  localparam logic [2:0] KIND_PROGRAM = 3'd3;
  localparam logic [2:0] KIND_INITIAL = 3'd4;

  // opcodes
  localparam logic [1:0] OPC_PAGE0 = 2'b10;
  localparam logic [1:0] OPC_PAGE1 = 2'b11;
  localparam logic [1:0] OPC_RESET = 2'b00;

  // register indexes
  localparam logic [IDX_W-1:0] REG_START_GAP    = 3'd0;
  localparam logic [IDX_W-1:0] REG_WRITE_GAP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_ZERO_BIT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_ONE_BIT      = 3'd3;
  localparam logic [IDX_W-1:0] REG_PROGRAM      = 3'd4;
  localparam logic [IDX_W-1:0] REG_INITIAL_WAIT = 3'd5;

  // register reset values
  localparam logic [CLK_W-1:0] RST_START_GAP    = 10'd30;
  localparam logic [CLK_W-1:0] RST_WRITE_GAP    = 10'd18;
  localparam logic [CLK_W-1:0] RST_ZERO_BIT     = 10'd24;
  localparam logic [CLK_W-1:0] RST_ONE_BIT      = 10'd56;
  localparam logic [CLK_W-1:0] RST_PROGRAM      = 10'd700;
  localparam logic [CLK_W-1:0] RST_INITIAL_WAIT = 10'd400;

  // symbol positions in the full sequence; bit symbols fill the rest
  localparam logic [POS_W-1:0] POS_INIT        = 6'd0;
  localparam logic [POS_W-1:0] POS_START       = 6'd1;
  localparam logic [POS_W-1:0] POS_PROGRAM     = POS_W'(DATA_BITS + 8);
  localparam logic [POS_W-1:0] POS_RESET_START = POS_W'(DATA_BITS + 9);
  localparam logic [POS_W-1:0] POS_RESET_WAIT  = POS_W'(DATA_BITS + 12);

  typedef struct packed {
    logic                 page;
    logic [2:0]           block_index;
    logic                 lock_flag;
    logic [DATA_BITS-1:0] data_word;
    logic                 session_first;
  } cmd_in_t;

  typedef struct packed {
    logic [2:0]       symbol_kind;
    logic [CLK_W-1:0] carrier_on_clocks;
    logic [CLK_W-1:0] gap_clocks;
    logic             last_symbol;
  } symbol_t;

  // classified command as held in the queue
  typedef struct packed {
    logic                session_first;
    logic                with_reset;
    logic [STREAM_W-1:0] stream;
  } cmd_t;

  typedef struct packed {
    logic [CLK_W-1:0] start_gap;
    logic [CLK_W-1:0] write_gap;
    logic [CLK_W-1:0] zero_bit;
    logic [CLK_W-1:0] one_bit;
    logic [CLK_W-1:0] prog_wait;
    logic [CLK_W-1:0] initial_wait;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic last;
  } back_status_t;

endpackage

// ===== hw/rtl/rtbw_front.sv =====
// front end: takes a command beat and classifies it into a queue entry
// depends on rtbw_pkg
`timescale 1ns / 1ps

module rtbw_front (
  input  logic             start,
  input  logic             queue_full,
  input  rtbw_pkg::cmd_in_t in_data,
  output logic             busy,
  output logic             push,
  output rtbw_pkg::cmd_t   push_cmd
);

  logic [1:0] opcode;

  // accept whenever the queue has room
  assign busy = queue_full;
  assign push = start && !queue_full;

  // page selects the opcode
  assign opcode = in_data.page ? rtbw_pkg::OPC_PAGE1 : rtbw_pkg::OPC_PAGE0;

  // flatten every bit symbol into one stream, reset opcode at the tail
  always_comb begin
    push_cmd.session_first = in_data.session_first;
    push_cmd.with_reset    = (in_data.block_index == 3'd0);
    push_cmd.stream        = {opcode, in_data.lock_flag, in_data.data_word,
                              in_data.block_index, rtbw_pkg::OPC_RESET};
  end

endmodule

// ===== hw/rtl/rtbw_cmd_queue.sv =====
// two-entry command queue between front and back
// depends on rtbw_pkg
`timescale 1ns / 1ps

module rtbw_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtbw_pkg::cmd_t push_cmd,
  input  logic           pop,
  output rtbw_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           not_empty
);

  rtbw_pkg::cmd_t                     entry_r [rtbw_pkg::QUEUE_DEPTH];
  logic [rtbw_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [rtbw_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [rtbw_pkg::QCNT_W-1:0]        count_r, count_nxt;
  logic                               do_pop;

  assign full      = (count_r == rtbw_pkg::QCNT_W'(rtbw_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = entry_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/rtbw_back.sv =====
// back end: walks one command's symbol sequence, one symbol beat a cycle
// depends on rtbw_pkg
`timescale 1ns / 1ps

module rtbw_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rtbw_pkg::cfg_t         cfg,
  input  rtbw_pkg::cmd_t         head_cmd,
  input  logic                   queue_not_empty,
  output logic                   pop,
  output rtbw_pkg::back_status_t status,
  output logic                   out_valid,
  output rtbw_pkg::symbol_t      out_data
);

  logic                              active_r, active_nxt;
  logic [rtbw_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [rtbw_pkg::STREAM_W-1:0]     stream_r, stream_nxt;
  logic                              with_reset_r, with_reset_nxt;
  logic                              out_valid_r, out_valid_nxt;
  rtbw_pkg::symbol_t                 out_data_r, out_data_nxt;
  logic                              sym_last;
  logic                              sym_is_bit;

  // current symbol from position and stream head
  always_comb begin
    sym_is_bit = 1'b0;
    out_data_nxt = '0;
    case (pos_r)
      rtbw_pkg::POS_INIT, rtbw_pkg::POS_RESET_WAIT: begin
        out_data_nxt.symbol_kind       = rtbw_pkg::KIND_INITIAL;
        out_data_nxt.carrier_on_clocks = cfg.initial_wait;
      end
      rtbw_pkg::POS_START, rtbw_pkg::POS_RESET_START: begin
        out_data_nxt.symbol_kind = rtbw_pkg::KIND_START;
        out_data_nxt.gap_clocks  = cfg.start_gap;
      end
      rtbw_pkg::POS_PROGRAM: begin
        out_data_nxt.symbol_kind       = rtbw_pkg::KIND_PROGRAM;
        out_data_nxt.carrier_on_clocks = cfg.prog_wait;
      end
      default: begin
        sym_is_bit              = 1'b1;
        out_data_nxt.gap_clocks = cfg.write_gap;
        if (stream_r[rtbw_pkg::STREAM_W-1]) begin
          out_data_nxt.symbol_kind       = rtbw_pkg::KIND_ONE;
          out_data_nxt.carrier_on_clocks = cfg.one_bit;
        end else begin
          out_data_nxt.symbol_kind       = rtbw_pkg::KIND_ZERO;
          out_data_nxt.carrier_on_clocks = cfg.zero_bit;
        end
      end
    endcase
    sym_last = (pos_r == rtbw_pkg::POS_RESET_WAIT) ||
               ((pos_r == rtbw_pkg::POS_PROGRAM) && !with_reset_r);
    out_data_nxt.last_symbol = sym_last;
    out_valid_nxt = active_r;
  end

  // sequencing and next command load
  always_comb begin
    pop            = queue_not_empty && (!active_r || sym_last);
    active_nxt     = active_r;
    pos_nxt        = pos_r;
    stream_nxt     = stream_r;
    with_reset_nxt = with_reset_r;
    if (active_r) begin
      pos_nxt = pos_r + 1'b1;
      if (sym_is_bit) begin
        stream_nxt = {stream_r[rtbw_pkg::STREAM_W-2:0], 1'b0};
      end
      if (sym_last) begin
        active_nxt = 1'b0;
      end
    end
    if (pop) begin
      active_nxt     = 1'b1;
      pos_nxt        = head_cmd.session_first ? rtbw_pkg::POS_INIT : rtbw_pkg::POS_START;
      stream_nxt     = head_cmd.stream;
      with_reset_nxt = head_cmd.with_reset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    stream_r     <= stream_nxt;
    with_reset_r <= with_reset_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign status.active = active_r;
  assign status.last   = active_r && sym_last;

endmodule

// ===== hw/rtl/rfid_tag_block_write_encoder_core.sv =====
// top level of the block write encoder: config registers, front, queue, back
// depends on rtbw_pkg, rtbw_front, rtbw_cmd_queue, rtbw_back and the defines header
`timescale 1ns / 1ps

// A block-write command is taken when start is high and busy is low. It turns
// into 40 to 45 symbol beats on out_data, one per clock with out_valid high,
// the final one flagged by last_symbol: 40 plus one with session_first, plus
// four more for block 0. The back-end sequencer emits one symbol per clock,
// and symbols of consecutive commands follow with no gap when the next one is
// already queued. A two-entry queue sits in front of it, so commands are taken
// while symbols are still going out; busy is high while that queue is full.
// The output has no stall: every beat must be taken in the cycle it is shown.
// Registers must be written only while no command is in flight; the block
// itself does not enforce this.

`include "rfid_tag_block_write_encoder_core_defines.svh"

module rfid_tag_block_write_encoder_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  rtbw_pkg::cmd_in_t                     in_data,
  output logic                                  out_valid,
  output rtbw_pkg::symbol_t                     out_data,
  input  logic                                  cfg_we,
  input  logic [rtbw_pkg::IDX_W-1:0]            cfg_index,
  input  logic [rtbw_pkg::CLK_W-1:0]            cfg_wdata
);

  rtbw_pkg::cfg_t         cfg_r, cfg_nxt;
  rtbw_pkg::cmd_t         push_cmd;
  rtbw_pkg::cmd_t         head_cmd;
  rtbw_pkg::back_status_t back_status;
  logic                   push;
  logic                   pop;
  logic                   queue_full;
  logic                   queue_not_empty;
  logic                   wait_beat;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rtbw_pkg::REG_START_GAP:    cfg_nxt.start_gap    = cfg_wdata;
        rtbw_pkg::REG_WRITE_GAP:    cfg_nxt.write_gap    = cfg_wdata;
        rtbw_pkg::REG_ZERO_BIT:     cfg_nxt.zero_bit     = cfg_wdata;
        rtbw_pkg::REG_ONE_BIT:      cfg_nxt.one_bit      = cfg_wdata;
        rtbw_pkg::REG_PROGRAM:      cfg_nxt.prog_wait    = cfg_wdata;
        rtbw_pkg::REG_INITIAL_WAIT: cfg_nxt.initial_wait = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_gap    <= rtbw_pkg::RST_START_GAP;
      cfg_r.write_gap    <= rtbw_pkg::RST_WRITE_GAP;
      cfg_r.zero_bit     <= rtbw_pkg::RST_ZERO_BIT;
      cfg_r.one_bit      <= rtbw_pkg::RST_ONE_BIT;
      cfg_r.prog_wait    <= rtbw_pkg::RST_PROGRAM;
      cfg_r.initial_wait <= rtbw_pkg::RST_INITIAL_WAIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // command intake and classification
  rtbw_front u_front (
    .start      (start),
    .queue_full (queue_full),
    .in_data    (in_data),
    .busy       (busy),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // decoupling queue
  rtbw_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .full      (queue_full),
    .not_empty (queue_not_empty)
  );

  // symbol sequencer
  rtbw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_cmd        (head_cmd),
    .queue_not_empty (queue_not_empty),
    .pop             (pop),
    .status          (back_status),
    .out_valid       (out_valid),
    .out_data        (out_data)
  );

  // program and initial waits on the output
  assign wait_beat = out_valid &&
                     (out_data.symbol_kind == rtbw_pkg::KIND_PROGRAM ||
                      out_data.symbol_kind == rtbw_pkg::KIND_INITIAL);

  // checks
  `RTBW_ASSERT_NOW(a_no_overflow, push, !queue_full)
  `RTBW_ASSERT_NOW(a_wait_no_gap, wait_beat, out_data.gap_clocks == '0)
  `RTBW_ASSERT_NEXT(a_back_to_back, back_status.last && queue_not_empty, back_status.active)
  `RTBW_ASSERT_TWO(a_idle_pickup, push && !queue_not_empty && !back_status.active, back_status.active)

endmodule
